// ===== src/lms_pkg.sv =====
// Shared types, codes and helpers of the lift mechanism sequencer.
// No dependencies; imported by lms_step and lift_mechanism_sequencer.
package lms_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int MODE_CODE_WIDTH     = 4;
   localparam logic [CFG_WIDTH-1:0] WAIT_TICKS_RESET = CFG_WIDTH'(50);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROLLER_WAIT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNDO_WAIT   = 1'b1;

   typedef enum logic [3:0] {
      REQ_TICK      = 4'd0,
      REQ_START     = 4'd1,
      REQ_STOP      = 4'd2,
      REQ_UP        = 4'd3,
      REQ_DOWN      = 4'd4,
      REQ_SING_UP   = 4'd5,
      REQ_SING_DOWN = 4'd6,
      REQ_REORIENT  = 4'd7,
      REQ_DONE      = 4'd8,
      REQ_OVR_ON    = 4'd9,
      REQ_OVR_OFF   = 4'd10
   } req_code_type;

   typedef enum logic [12:0] {
      MODE_INIT      = 13'b0000000000001,
      MODE_SAFETY    = 13'b0000000000010,
      MODE_BRAKING   = 13'b0000000000100,
      MODE_BOTTOM    = 13'b0000000001000,
      MODE_UP        = 13'b0000000010000,
      MODE_DOWN      = 13'b0000000100000,
      MODE_ARMS_IN   = 13'b0000001000000,
      MODE_ARMS_OUT  = 13'b0000010000000,
      MODE_SING_DOWN = 13'b0000100000000,
      MODE_SING_UP   = 13'b0001000000000,
      MODE_REORIENT  = 13'b0010000000000,
      MODE_WAIT_UNDO = 13'b0100000000000,
      MODE_OVERRIDE  = 13'b1000000000000
   } mode_type;

   typedef enum logic [1:0] {
      LIFT_STOP = 2'd0,
      LIFT_UP   = 2'd1,
      LIFT_DOWN = 2'd2
   } lift_type;

   typedef struct packed {
      logic hook_raise;
      logic hook_extend;
      logic reorient;
      logic arm;
      logic brake;
   } valve_type;

   typedef struct packed {
      req_code_type code;
      logic         top;
      logic         bottom;
      logic         tote;
   } request_type;

   // Binary mode number reported on the result channel.
   function automatic logic [MODE_CODE_WIDTH-1:0] mode_code(mode_type m);
      logic [MODE_CODE_WIDTH-1:0] code;
      case (m)
         MODE_INIT:      code = 4'd0;
         MODE_SAFETY:    code = 4'd1;
         MODE_BRAKING:   code = 4'd2;
         MODE_BOTTOM:    code = 4'd3;
         MODE_UP:        code = 4'd4;
         MODE_DOWN:      code = 4'd5;
         MODE_ARMS_IN:   code = 4'd6;
         MODE_ARMS_OUT:  code = 4'd7;
         MODE_SING_DOWN: code = 4'd8;
         MODE_SING_UP:   code = 4'd9;
         MODE_REORIENT:  code = 4'd10;
         MODE_WAIT_UNDO: code = 4'd11;
         MODE_OVERRIDE:  code = 4'd12;
         default:        code = 4'd0;
      endcase
      return code;
   endfunction

endpackage

// ===== src/lms_step.sv =====
// Next-state logic of the lift mechanism sequencer: one request against the current state.
// Depends on lms_pkg.
module lms_step #(
   parameter int TIMER_WIDTH = lms_pkg::TIMER_WIDTH_DEFAULT
) (
   input  lms_pkg::request_type             request,
   input  lms_pkg::mode_type                mode_cur,
   input  lms_pkg::lift_type                lift_cur,
   input  lms_pkg::valve_type               valves_cur,
   input  logic [TIMER_WIDTH-1:0]           arms_in_cur,
   input  logic [TIMER_WIDTH-1:0]           arms_out_cur,
   input  logic [TIMER_WIDTH-1:0]           undo_cur,
   input  logic [lms_pkg::CFG_WIDTH-1:0]    roller_wait,
   input  logic [lms_pkg::CFG_WIDTH-1:0]    undo_wait,
   output lms_pkg::mode_type                mode_next,
   output lms_pkg::lift_type                lift_next,
   output lms_pkg::valve_type               valves_next,
   output logic [TIMER_WIDTH-1:0]           arms_in_next,
   output logic [TIMER_WIDTH-1:0]           arms_out_next,
   output logic [TIMER_WIDTH-1:0]           undo_next
);
   import lms_pkg::*;

   localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   logic [TIMER_WIDTH-1:0] arms_in_adv, arms_out_adv, undo_adv;
   logic [CMP_WIDTH-1:0]   roller_x, undo_wait_x;
   logic                   arms_in_done, arms_in_not_late, arms_out_done, undo_done;
   mode_type               work_target;
   logic                   braking_ok;

   // Saturating advance of the interval timers.
   assign arms_in_adv  = (arms_in_cur  == TIMER_MAX) ? arms_in_cur  : arms_in_cur  + 1'b1;
   assign arms_out_adv = (arms_out_cur == TIMER_MAX) ? arms_out_cur : arms_out_cur + 1'b1;
   assign undo_adv     = (undo_cur     == TIMER_MAX) ? undo_cur     : undo_cur     + 1'b1;

   assign roller_x    = CMP_WIDTH'(roller_wait);
   assign undo_wait_x = CMP_WIDTH'(undo_wait);

   // Commands compare unadvanced timers, ticks the advanced ones.
   assign arms_in_done     = CMP_WIDTH'(arms_in_cur) >= roller_x;
   assign arms_in_not_late = CMP_WIDTH'(arms_in_cur) <= roller_x;
   assign arms_out_done    = CMP_WIDTH'(arms_out_adv) >= roller_x;
   assign undo_done        = CMP_WIDTH'(undo_adv) >= undo_wait_x;

   always_comb begin
      case (request.code)
         REQ_SING_UP:   work_target = MODE_SING_UP;
         REQ_SING_DOWN: work_target = MODE_SING_DOWN;
         default:       work_target = MODE_REORIENT;
      endcase
   end

   assign braking_ok = (request.code != REQ_SING_UP) || !request.tote;

   always_comb begin
      mode_next     = mode_cur;
      lift_next     = lift_cur;
      valves_next   = valves_cur;
      arms_in_next  = arms_in_cur;
      arms_out_next = arms_out_cur;
      undo_next     = undo_cur;

      case (request.code)
         REQ_TICK: begin
            arms_in_next  = arms_in_adv;
            arms_out_next = arms_out_adv;
            undo_next     = undo_adv;
            case (mode_cur)
               MODE_INIT: begin
                  valves_next.brake = 1'b0;
                  lift_next         = LIFT_STOP;
               end
               MODE_SAFETY: begin
                  if (valves_cur.arm) begin
                     mode_next = MODE_WAIT_UNDO;
                  end else begin
                     mode_next = request.top ? MODE_BRAKING : MODE_INIT;
                  end
               end
               MODE_BRAKING: begin
                  lift_next         = LIFT_STOP;
                  valves_next.brake = 1'b1;
               end
               MODE_BOTTOM: begin
                  lift_next         = LIFT_STOP;
                  valves_next.brake = 1'b0;
                  mode_next         = MODE_INIT;
               end
               MODE_UP: begin
                  lift_next         = LIFT_UP;
                  valves_next.brake = 1'b0;
                  if (request.top) begin
                     mode_next = MODE_BRAKING;
                  end
               end
               MODE_DOWN: begin
                  lift_next         = LIFT_DOWN;
                  valves_next.brake = 1'b0;
                  if (request.bottom) begin
                     mode_next = MODE_BOTTOM;
                  end
               end
               MODE_ARMS_IN: begin
                  valves_next.arm = 1'b0;
               end
               MODE_WAIT_UNDO: begin
                  valves_next.reorient    = 1'b1;
                  valves_next.hook_extend = 1'b1;
                  valves_next.hook_raise  = 1'b1;
                  if (undo_done) begin
                     mode_next = MODE_ARMS_OUT;
                  end
               end
               MODE_ARMS_OUT: begin
                  valves_next.arm = 1'b1;
                  if (arms_out_done) begin
                     mode_next = request.top ? MODE_BRAKING : MODE_INIT;
                  end
               end
               MODE_SING_DOWN: begin
                  valves_next.hook_extend = 1'b0;
                  valves_next.hook_raise  = 1'b0;
               end
               MODE_SING_UP: begin
                  valves_next.hook_extend = 1'b0;
                  valves_next.hook_raise  = 1'b1;
               end
               MODE_REORIENT: begin
                  valves_next.reorient = 1'b0;
               end
               default: begin
               end
            endcase
         end
         REQ_START: begin
            mode_next = MODE_SAFETY;
         end
         REQ_STOP: begin
            if (mode_cur inside {MODE_UP, MODE_DOWN}) begin
               mode_next = MODE_INIT;
            end
         end
         REQ_UP: begin
            if ((mode_cur inside {MODE_INIT, MODE_DOWN}) && !request.top) begin
               mode_next = MODE_UP;
            end else if (mode_cur == MODE_OVERRIDE) begin
               lift_next = LIFT_UP;
            end
         end
         REQ_DOWN: begin
            if ((mode_cur inside {MODE_BRAKING, MODE_INIT, MODE_UP}) && !request.bottom) begin
               mode_next = MODE_DOWN;
            end else if (mode_cur == MODE_OVERRIDE) begin
               lift_next = LIFT_DOWN;
            end
         end
         REQ_SING_UP, REQ_SING_DOWN, REQ_REORIENT: begin
            if (mode_cur == MODE_ARMS_IN && arms_in_done) begin
               mode_next = work_target;
            end else if (mode_cur == MODE_ARMS_OUT) begin
               arms_in_next = '0;
               mode_next    = MODE_ARMS_IN;
            end else if (mode_cur == MODE_WAIT_UNDO) begin
               mode_next = work_target;
            end else if (mode_cur == MODE_BRAKING && braking_ok) begin
               arms_in_next = '0;
               mode_next    = MODE_ARMS_IN;
            end else if (mode_cur == MODE_OVERRIDE) begin
               if (request.code == REQ_REORIENT) begin
                  valves_next.reorient = 1'b0;
               end else begin
                  valves_next.hook_extend = 1'b0;
                  valves_next.hook_raise  = (request.code == REQ_SING_UP);
               end
            end else if (request.code == REQ_SING_UP && mode_cur == MODE_SING_DOWN) begin
               mode_next = MODE_SING_UP;
            end else if (request.code == REQ_SING_DOWN && mode_cur == MODE_SING_UP) begin
               mode_next = MODE_SING_DOWN;
            end
         end
         REQ_DONE: begin
            if (mode_cur inside {MODE_SING_DOWN, MODE_SING_UP, MODE_REORIENT}) begin
               undo_next = '0;
               mode_next = MODE_WAIT_UNDO;
            end else if (mode_cur == MODE_ARMS_IN && arms_in_not_late) begin
               arms_out_next = '0;
               mode_next     = MODE_ARMS_OUT;
            end else if (mode_cur == MODE_OVERRIDE) begin
               valves_next.hook_extend = 1'b1;
               valves_next.hook_raise  = 1'b1;
               valves_next.reorient    = 1'b1;
            end
         end
         REQ_OVR_ON: begin
            mode_next = MODE_OVERRIDE;
         end
         REQ_OVR_OFF: begin
            if (mode_cur == MODE_OVERRIDE) begin
               mode_next = MODE_INIT;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/lift_mechanism_sequencer.sv =====
// Top level of the lift mechanism sequencer: request register, state/result registers,
// configuration registers. Depends on lms_pkg and lms_step.
//
// Usage:
//  - Request channel (req_valid/req_stall): one tick or operator command per request,
//    with the limit-switch and tote-present levels sampled alongside.
//  - Result channel (rsp_valid/rsp_stall): one result per request, the mode and the
//    drive and valve levels after that request.
//  - Configuration port (csr_*): write the two wait counts while the block is idle.
//  - Throughput: one request per cycle unless a waiting result is stalled; the state
//    update is one pass of lms_step between the request register and the state
//    registers, which also serve as the result register.
//  - Stall: while a result waits, the request register holds one more request and
//    req_stall rises only when that register is full as well.
//  - Reset: mode init, timers and levels zero, both wait counts 50, channels empty.
module lift_mechanism_sequencer #(
   parameter int TIMER_WIDTH = lms_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [3:0]                            req_type,
   input  logic                                  req_top_switch_closed,
   input  logic                                  req_bottom_switch_closed,
   input  logic                                  req_tote_present,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lms_pkg::MODE_CODE_WIDTH-1:0]   rsp_mode,
   output logic [1:0]                            rsp_lift_drive,
   output logic                                  rsp_brake_on,
   output logic                                  rsp_arm_valve,
   output logic                                  rsp_reorient_valve,
   output logic                                  rsp_hook_extend_valve,
   output logic                                  rsp_hook_raise_valve,
   // configuration port
   input  logic                                  csr_write_enable,
   input  logic [lms_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lms_pkg::CFG_WIDTH-1:0]         csr_write_data
);
   import lms_pkg::*;

   // request register
   logic        req_valid_ff, req_valid_in;
   request_type request_ff;

   // state registers; their outputs are the result payload
   logic                   rsp_valid_ff, rsp_valid_in;
   mode_type               mode_ff, mode_in;
   lift_type               lift_ff, lift_in;
   valve_type              valves_ff, valves_in;
   logic [TIMER_WIDTH-1:0] arms_in_ff, arms_in_in;
   logic [TIMER_WIDTH-1:0] arms_out_ff, arms_out_in;
   logic [TIMER_WIDTH-1:0] undo_ff, undo_in;

   // configuration registers
   logic [CFG_WIDTH-1:0] roller_wait_ff, undo_wait_ff;

   logic req_accept;
   logic step_fire;

   // Advance the held request whenever the result slot is free or being taken.
   assign step_fire  = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = req_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         req_valid_in = 1'b1;
      end else if (step_fire) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   // Hold a stalled result; drop it once taken unless a new one replaces it.
   assign rsp_valid_in = step_fire || (rsp_valid_ff && rsp_stall);

   lms_step #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .request       (request_ff),
      .mode_cur      (mode_ff),
      .lift_cur      (lift_ff),
      .valves_cur    (valves_ff),
      .arms_in_cur   (arms_in_ff),
      .arms_out_cur  (arms_out_ff),
      .undo_cur      (undo_ff),
      .roller_wait   (roller_wait_ff),
      .undo_wait     (undo_wait_ff),
      .mode_next     (mode_in),
      .lift_next     (lift_in),
      .valves_next   (valves_in),
      .arms_in_next  (arms_in_in),
      .arms_out_next (arms_out_in),
      .undo_next     (undo_in)
   );

   // Request payload: load on accept, no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         request_ff <= '{code:   req_code_type'(req_type),
                         top:    req_top_switch_closed,
                         bottom: req_bottom_switch_closed,
                         tote:   req_tote_present};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_INIT;
         lift_ff      <= LIFT_STOP;
         valves_ff    <= '0;
         arms_in_ff   <= '0;
         arms_out_ff  <= '0;
         undo_ff      <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            mode_ff     <= mode_in;
            lift_ff     <= lift_in;
            valves_ff   <= valves_in;
            arms_in_ff  <= arms_in_in;
            arms_out_ff <= arms_out_in;
            undo_ff     <= undo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roller_wait_ff <= WAIT_TICKS_RESET;
         undo_wait_ff   <= WAIT_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROLLER_WAIT: roller_wait_ff <= csr_write_data;
            CSR_UNDO_WAIT:   undo_wait_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mode              = mode_code(mode_ff);
   assign rsp_lift_drive        = lift_ff;
   assign rsp_brake_on          = valves_ff.brake;
   assign rsp_arm_valve         = valves_ff.arm;
   assign rsp_reorient_valve    = valves_ff.reorient;
   assign rsp_hook_extend_valve = valves_ff.hook_extend;
   assign rsp_hook_raise_valve  = valves_ff.hook_raise;

   // A processed start always lands in safety.
   a_start_to_safety: assert property (@(posedge clock) disable iff (reset)
      (step_fire && request_ff.code == REQ_START) |=> (mode_ff == MODE_SAFETY))
      else $error("start request did not enter safety");

   // A tick in up mode drives the lift up.
   a_up_drives_lift: assert property (@(posedge clock) disable iff (reset)
      (step_fire && request_ff.code == REQ_TICK && mode_ff == MODE_UP)
      |=> (lift_ff == LIFT_UP))
      else $error("tick in up mode did not drive lift up");

   // A request held behind a stalled result stays in the request register.
   a_hold_behind_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && rsp_stall)
      |=> (req_valid_ff && $stable(request_ff)))
      else $error("held request lost while result stalled");

endmodule
